// ===== src/css_pkg.sv =====
package css_pkg;

    // Configuration register indexes on the write port.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_REARM       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SORT_FIRST  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SORT_SECOND = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SORT_END    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_JOG_BACK    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RETRIES = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_REARM       = 16'd1500;
    localparam logic [15:0] RST_TIMEOUT     = 16'd30000;
    localparam logic [15:0] RST_SORT_FIRST  = 16'd7000;
    localparam logic [15:0] RST_SORT_SECOND = 16'd17000;
    localparam logic [15:0] RST_SORT_END    = 16'd25000;
    localparam logic [15:0] RST_JOG_BACK    = 16'd1000;
    localparam logic [1:0]  RST_MAX_RETRIES = 2'd2;

    // Phase codes as seen on the result port.
    localparam logic [1:0] PHASE_MOVING = 2'd0;
    localparam logic [1:0] PHASE_WAIT   = 2'd1;
    localparam logic [1:0] PHASE_SORT   = 2'd2;
    localparam logic [1:0] PHASE_JOG    = 2'd3;

    // Classification codes.
    localparam logic [1:0] CLS_METAL   = 2'd0;
    localparam logic [1:0] CLS_PAPER   = 2'd1;
    localparam logic [1:0] CLS_PLASTIC = 2'd2;
    localparam logic [1:0] CLS_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [15:0] rearm_ms;
        logic [15:0] class_wait_ms;
        logic [15:0] sort_first_ms;
        logic [15:0] sort_second_ms;
        logic [15:0] sort_end_ms;
        logic [15:0] jog_ms;
        logic [1:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic       object_present;
        logic       class_valid;
        logic [1:0] class_code;
    } t_item;

    typedef struct packed {
        logic       belt_run;
        logic       belt_reverse;
        logic       gates_set;
        logic       gate_one;
        logic       gate_two;
        logic       ready_led;
        logic       busy_led;
        logic       capture_request;
        logic [1:0] phase;
    } t_result;

endpackage

// ===== src/css_cfg.sv =====
module css_cfg
    import css_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rearm_ms       <= RST_REARM;
            r_cfg.class_wait_ms  <= RST_TIMEOUT;
            r_cfg.sort_first_ms  <= RST_SORT_FIRST;
            r_cfg.sort_second_ms <= RST_SORT_SECOND;
            r_cfg.sort_end_ms    <= RST_SORT_END;
            r_cfg.jog_ms         <= RST_JOG_BACK;
            r_cfg.max_retries    <= RST_MAX_RETRIES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REARM:       r_cfg.rearm_ms       <= i_cfg_data;
                REG_TIMEOUT:     r_cfg.class_wait_ms  <= i_cfg_data;
                REG_SORT_FIRST:  r_cfg.sort_first_ms  <= i_cfg_data;
                REG_SORT_SECOND: r_cfg.sort_second_ms <= i_cfg_data;
                REG_SORT_END:    r_cfg.sort_end_ms    <= i_cfg_data;
                REG_JOG_BACK:    r_cfg.jog_ms         <= i_cfg_data;
                REG_MAX_RETRIES: r_cfg.max_retries    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/css_seq.sv =====
module css_seq
    import css_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // Compare width covers both the tick counter and the 16-bit settings.
    localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TMAX   = {TIME_BITS{1'b1}};
    localparam logic [CW-1:0]        TMAX_W = CW'(TMAX);

    typedef enum logic [1:0] {
        ST_MOVING = 2'd0,
        ST_WAIT   = 2'd1,
        ST_SORT   = 2'd2,
        ST_JOG    = 2'd3
    } t_phase;

    t_phase               r_phase,      n_phase;
    logic [TIME_BITS-1:0] r_elapsed,    n_elapsed;
    logic                 r_armed,      n_armed;
    logic [1:0]           r_retry,      n_retry;
    logic                 r_pend_valid, n_pend_valid;
    logic [1:0]           r_pend_class, n_pend_class;
    logic [15:0]          r_sort_limit, n_sort_limit;
    logic [1:0]           r_belt,       n_belt;      // {reverse, run}
    logic [2:0]           r_gate,       n_gate;      // {two, one, set}
    logic [1:0]           r_led,        n_led;       // {busy, ready}
    logic                 n_capture;

    logic [CW-1:0]        el_w;
    logic [CW-1:0]        rearm_w;
    logic [TIME_BITS-1:0] rearm_clip;
    logic                 moved;
    logic [TIME_BITS-1:0] moved_elapsed;

    function automatic logic [2:0] gate_code(input logic [1:0] cls);
        logic [2:0] g;
        case (cls)
            CLS_METAL:   g = 3'b001;
            CLS_PAPER:   g = 3'b101;
            CLS_PLASTIC: g = 3'b011;
            default:     g = 3'b101;
        endcase
        return g;
    endfunction

    always_comb begin
        el_w       = CW'(r_elapsed);
        rearm_w    = CW'(i_cfg.rearm_ms);
        rearm_clip = (rearm_w > TMAX_W) ? TMAX : rearm_w[TIME_BITS-1:0];

        n_phase       = r_phase;
        n_armed       = r_armed;
        n_retry       = r_retry;
        n_pend_valid  = r_pend_valid | i_item.class_valid;
        n_pend_class  = i_item.class_valid ? i_item.class_code : r_pend_class;
        n_sort_limit  = r_sort_limit;
        n_belt        = r_belt;
        n_gate        = r_gate;
        n_led         = r_led;
        n_capture     = 1'b0;
        moved         = 1'b0;
        moved_elapsed = '0;

        unique case (r_phase)
            ST_MOVING: begin
                if (!(el_w < rearm_w)) begin
                    n_armed  = r_armed | ~i_item.object_present;
                    n_led[0] = n_armed;
                    if (n_armed && i_item.object_present) begin
                        n_armed      = 1'b0;
                        n_led        = 2'b10;
                        n_belt       = 2'b00;
                        n_capture    = 1'b1;
                        n_pend_valid = 1'b0;
                        n_pend_class = CLS_METAL;
                        n_retry      = 2'd0;
                        n_phase      = ST_WAIT;
                        moved        = 1'b1;
                    end
                end
            end
            ST_WAIT: begin
                if (n_pend_valid) begin
                    if (n_pend_class == CLS_UNKNOWN && r_retry < i_cfg.max_retries) begin
                        n_retry = r_retry + 2'd1;
                        n_belt  = 2'b11;
                        n_phase = ST_JOG;
                        moved   = 1'b1;
                    end else begin
                        n_led[1] = 1'b0;
                        n_gate   = gate_code(n_pend_class);
                        case (n_pend_class)
                            CLS_METAL: n_sort_limit = i_cfg.sort_end_ms;
                            CLS_PAPER: n_sort_limit = i_cfg.sort_second_ms;
                            default:   n_sort_limit = i_cfg.sort_first_ms;
                        endcase
                        n_belt[0] = 1'b1;
                        n_phase   = ST_SORT;
                        moved     = 1'b1;
                    end
                end else if (el_w > CW'(i_cfg.class_wait_ms)) begin
                    n_led[1]     = 1'b0;
                    n_gate       = gate_code(CLS_UNKNOWN);
                    n_sort_limit = i_cfg.sort_first_ms;
                    n_belt[0]    = 1'b1;
                    n_phase      = ST_SORT;
                    moved        = 1'b1;
                end
            end
            ST_SORT: begin
                if (el_w > CW'(r_sort_limit)) begin
                    n_gate  = 3'b000;
                    n_phase = ST_MOVING;
                    moved   = 1'b1;
                end
            end
            ST_JOG: begin
                // Leaving the jog skips the rearm wait.
                if (el_w > CW'(i_cfg.jog_ms)) begin
                    n_belt        = 2'b01;
                    n_phase       = ST_MOVING;
                    moved         = 1'b1;
                    moved_elapsed = rearm_clip;
                end
            end
            default: ;
        endcase

        if (moved) begin
            n_elapsed = moved_elapsed;
        end else if (r_elapsed != TMAX) begin
            n_elapsed = r_elapsed + 1'b1;
        end else begin
            n_elapsed = r_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ST_MOVING;
            r_elapsed    <= '0;
            r_armed      <= 1'b1;
            r_retry      <= 2'd0;
            r_pend_valid <= 1'b0;
            r_pend_class <= CLS_METAL;
            r_sort_limit <= RST_SORT_END;
            r_belt       <= 2'b01;
            r_gate       <= 3'b000;
            r_led        <= 2'b00;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_elapsed    <= n_elapsed;
            r_armed      <= n_armed;
            r_retry      <= n_retry;
            r_pend_valid <= n_pend_valid;
            r_pend_class <= n_pend_class;
            r_sort_limit <= n_sort_limit;
            r_belt       <= n_belt;
            r_gate       <= n_gate;
            r_led        <= n_led;
        end
    end

    always_comb begin
        o_result.belt_run        = n_belt[0];
        o_result.belt_reverse    = n_belt[1];
        o_result.gates_set       = n_gate[0];
        o_result.gate_one        = n_gate[0] & n_gate[1];
        o_result.gate_two        = n_gate[0] & n_gate[2];
        o_result.ready_led       = n_led[0];
        o_result.busy_led        = n_led[1];
        o_result.capture_request = n_capture;
        o_result.phase           = n_phase;
    end

endmodule

// ===== src/conveyor_sort_sequencer_core.sv =====
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while the result side does not stall; the sequencer state
// updates in the same cycle that the input register hands its request to the result register.
// Reset (i_rst_n low, synchronous): pipeline empty, phase moving, belt forward, gates at rest,
// sensor armed, settings back to their default values.
module conveyor_sort_sequencer_core
    import css_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // Configuration write port.
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,

    // Tick request channel.
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_object_present,
    input  logic                     i_class_valid,
    input  logic [1:0]               i_class_code,

    // Result channel.
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_belt_run,
    output logic                     o_belt_reverse,
    output logic                     o_gates_set,
    output logic                     o_gate_one,
    output logic                     o_gate_two,
    output logic                     o_ready_led,
    output logic                     o_busy_led,
    output logic                     o_capture_request,
    output logic [1:0]               o_phase
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result seq_result;
    logic    fire;
    logic    can_take;

    // A request moves from the input register to the result register whenever the
    // result register is empty or is being drained this cycle. The sequencer state
    // advances on exactly that move, so requests are processed strictly in order.
    assign fire     = r_in_valid && (!r_out_valid || !i_stall);
    assign can_take = !r_in_valid || fire;
    assign o_stall  = !can_take;

    css_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    css_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    // Input register: the skid point for the tick channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && can_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && can_take) begin
            r_in.object_present <= i_object_present;
            r_in.class_valid    <= i_class_valid;
            r_in.class_code     <= i_class_code;
        end
    end

    // Result register: holds its value while the downstream side stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= seq_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_belt_run        = r_out.belt_run;
    assign o_belt_reverse    = r_out.belt_reverse;
    assign o_gates_set       = r_out.gates_set;
    assign o_gate_one        = r_out.gate_one;
    assign o_gate_two        = r_out.gate_two;
    assign o_ready_led       = r_out.ready_led;
    assign o_busy_led        = r_out.busy_led;
    assign o_capture_request = r_out.capture_request;
    assign o_phase           = r_out.phase;

    // A capture request is only issued on the tick that enters the waiting phase.
    a_capture_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_capture_request |-> o_phase == PHASE_WAIT)
        else $error("capture request outside the waiting phase");

    // Gate command bits are masked while the gates are at rest.
    a_gates_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_gates_set |-> !o_gate_one && !o_gate_two)
        else $error("gate command active while gates at rest");

    // The belt only runs backward while jogging back, and then it is running.
    a_reverse_only_jog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_belt_reverse |-> o_phase == PHASE_JOG && o_belt_run)
        else $error("belt reversed outside the jog phase");

    // A request taken in while nothing is in flight passes the input and result registers unstalled.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !r_in_valid && !o_valid |=> ##1 o_valid)
        else $error("result missing after accepted request");

endmodule

// ===== sim/tb.sv =====
module tb;
    import css_pkg::*;

    // Run limits.
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int MAX_REPORTS      = 10;
    // The receiver holds off once for a long stretch after this many results.
    localparam int LONG_HOLD_AFTER  = 500;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_object_present = 1'b0;
    logic                     i_class_valid = 1'b0;
    logic [1:0]               i_class_code = 2'd0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_belt_run;
    logic                     o_belt_reverse;
    logic                     o_gates_set;
    logic                     o_gate_one;
    logic                     o_gate_two;
    logic                     o_ready_led;
    logic                     o_busy_led;
    logic                     o_capture_request;
    logic [1:0]               o_phase;

    conveyor_sort_sequencer_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_object_present  (i_object_present),
        .i_class_valid     (i_class_valid),
        .i_class_code      (i_class_code),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_belt_run        (o_belt_run),
        .o_belt_reverse    (o_belt_reverse),
        .o_gates_set       (o_gates_set),
        .o_gate_one        (o_gate_one),
        .o_gate_two        (o_gate_two),
        .o_ready_led       (o_ready_led),
        .o_busy_led        (o_busy_led),
        .o_capture_request (o_capture_request),
        .o_phase           (o_phase)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Tick requests waiting to be offered, and the outputs predicted for the
    // ticks the block has already taken.
    t_item   tick_q[$];
    t_result expected_outputs[$];

    int ticks_queued = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int idle_pct     = 0;

    // Sequencer state as the predictor sees it, plus its copy of the settings.
    t_cfg        cfg;
    logic [1:0]  st_phase;
    logic [15:0] st_elapsed;
    logic        st_armed;
    logic [1:0]  st_retries;
    logic        st_pend_valid;
    logic [1:0]  st_pend_class;
    logic [15:0] st_sort_limit;
    logic        st_run, st_reverse;
    logic        st_gates_set, st_gate_one, st_gate_two;
    logic        st_ready, st_busy;

    // Gate pattern {gate_one, gate_two} for a class; unknown shares the paper chute.
    function automatic logic [1:0] gate_pattern(input logic [1:0] cls);
        case (cls)
            CLS_METAL:   return 2'b00;
            CLS_PAPER:   return 2'b01;
            CLS_PLASTIC: return 2'b10;
            default:     return 2'b01;
        endcase
    endfunction

    // Advances the predicted sequencer by one millisecond tick and returns
    // the outputs it shows after that tick.
    function automatic t_result advance_sequencer(input t_item tick);
        t_result     r;
        logic        changed;
        logic        capture;
        logic [15:0] next_elapsed;
        changed = 1'b0;
        capture = 1'b0;
        next_elapsed = '0;

        // A class result is latched whatever the phase.
        if (tick.class_valid) begin
            st_pend_valid = 1'b1;
            st_pend_class = tick.class_code;
        end

        case (st_phase)
            PHASE_MOVING: begin
                // Inside the rearm window the sensor and ready LED are frozen.
                if (st_elapsed >= cfg.rearm_ms) begin
                    if (!tick.object_present)
                        st_armed = 1'b1;
                    st_ready = st_armed;
                    if (st_armed && tick.object_present) begin
                        // Stop the belt and ask for a capture; a class result on
                        // this very tick is thrown away with the old one.
                        st_armed = 1'b0;
                        st_ready = 1'b0;
                        st_busy = 1'b1;
                        st_run = 1'b0;
                        st_reverse = 1'b0;
                        capture = 1'b1;
                        st_pend_valid = 1'b0;
                        st_pend_class = CLS_METAL;
                        st_retries = '0;
                        st_phase = PHASE_WAIT;
                        changed = 1'b1;
                    end
                end
            end
            PHASE_WAIT: begin
                if (st_pend_valid) begin
                    if (st_pend_class == CLS_UNKNOWN && st_retries < cfg.max_retries) begin
                        st_retries = st_retries + 2'd1;
                        st_run = 1'b1;
                        st_reverse = 1'b1;
                        st_phase = PHASE_JOG;
                    end else begin
                        st_busy = 1'b0;
                        st_gates_set = 1'b1;
                        {st_gate_one, st_gate_two} = gate_pattern(st_pend_class);
                        case (st_pend_class)
                            CLS_METAL: st_sort_limit = cfg.sort_end_ms;
                            CLS_PAPER: st_sort_limit = cfg.sort_second_ms;
                            default:   st_sort_limit = cfg.sort_first_ms;
                        endcase
                        st_run = 1'b1;
                        st_phase = PHASE_SORT;
                    end
                    changed = 1'b1;
                end else if (st_elapsed > cfg.class_wait_ms) begin
                    // No answer in time: sort it as unknown.
                    st_busy = 1'b0;
                    st_gates_set = 1'b1;
                    {st_gate_one, st_gate_two} = gate_pattern(CLS_UNKNOWN);
                    st_sort_limit = cfg.sort_first_ms;
                    st_run = 1'b1;
                    st_phase = PHASE_SORT;
                    changed = 1'b1;
                end
            end
            PHASE_SORT: begin
                if (st_elapsed > st_sort_limit) begin
                    st_gates_set = 1'b0;
                    st_gate_one = 1'b0;
                    st_gate_two = 1'b0;
                    st_phase = PHASE_MOVING;
                    changed = 1'b1;
                end
            end
            default: begin
                // The end of a jog skips the rearm window.
                if (st_elapsed > cfg.jog_ms) begin
                    st_run = 1'b1;
                    st_reverse = 1'b0;
                    st_phase = PHASE_MOVING;
                    changed = 1'b1;
                    next_elapsed = cfg.rearm_ms;
                end
            end
        endcase

        if (changed)
            st_elapsed = next_elapsed;
        else if (st_elapsed != TIME_MAX)
            st_elapsed = st_elapsed + 16'd1;

        r.belt_run        = st_run;
        r.belt_reverse    = st_reverse;
        r.gates_set       = st_gates_set;
        r.gate_one        = st_gates_set & st_gate_one;
        r.gate_two        = st_gates_set & st_gate_two;
        r.ready_led       = st_ready;
        r.busy_led        = st_busy;
        r.capture_request = capture;
        r.phase           = st_phase;
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("run=%b rev=%b gates=%b(%b%b) ready=%b busy=%b cap=%b phase=%0d",
                         r.belt_run, r.belt_reverse, r.gates_set, r.gate_one, r.gate_two,
                         r.ready_led, r.busy_led, r.capture_request, r.phase);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic queue_tick(input logic present, input logic cv, input logic [1:0] code);
        t_item t;
        t.object_present = present;
        t.class_valid = cv;
        t.class_code = code;
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    // One object passing by: a clear stretch, then the object held at the
    // sensor while class results trickle in, now and then followed by noise.
    task automatic queue_episode();
        int clear_len;
        int block_len;
        clear_len = $urandom_range(0, 12);
        block_len = $urandom_range(1, 14);
        repeat (clear_len)
            queue_tick(1'b0, $urandom_range(0, 9) == 0, 2'($urandom_range(0, 3)));
        repeat (block_len)
            queue_tick(1'b1, $urandom_range(0, 2) == 0, 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4))
                queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)));
        end
    endtask

    task automatic queue_random(input int count);
        int start;
        start = ticks_queued;
        while (ticks_queued - start < count)
            queue_episode();
    endtask

    // Returns once every queued tick has been taken and answered, then waits
    // out the two pipeline stages.
    task automatic wait_results();
        while (tick_q.size() != 0 || i_valid || expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_REARM:       cfg.rearm_ms = val;
            REG_TIMEOUT:     cfg.class_wait_ms = val;
            REG_SORT_FIRST:  cfg.sort_first_ms = val;
            REG_SORT_SECOND: cfg.sort_second_ms = val;
            REG_SORT_END:    cfg.sort_end_ms = val;
            REG_JOG_BACK:    cfg.jog_ms = val;
            default:         cfg.max_retries = val[1:0];
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] rearm, input logic [15:0] tmo,
                                  input logic [15:0] first, input logic [15:0] second,
                                  input logic [15:0] last, input logic [15:0] jog,
                                  input logic [15:0] retries);
        write_setting(REG_REARM, rearm);
        write_setting(REG_TIMEOUT, tmo);
        write_setting(REG_SORT_FIRST, first);
        write_setting(REG_SORT_SECOND, second);
        write_setting(REG_SORT_END, last);
        write_setting(REG_JOG_BACK, jog);
        write_setting(REG_MAX_RETRIES, retries);
    endtask

    // Request side: note each taken tick and predict its outputs.
    logic  req_taken = 1'b0;
    t_item taken_tick;

    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            taken_tick.object_present = i_object_present;
            taken_tick.class_valid = i_class_valid;
            taken_tick.class_code = i_class_code;
            expected_outputs.push_back(advance_sequencer(taken_tick));
        end
    end

    // Sender: a new tick goes out on the falling edge once the previous one
    // was taken, with occasional bursts of idle cycles after an item.
    int    tx_gap = 0;
    t_item next_tick;

    always @(negedge i_clk) begin
        if (i_valid && !req_taken) begin
            // Still waiting for the block: hold the request as it is.
        end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            i_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
            next_tick = tick_q.pop_front();
            i_valid <= 1'b1;
            i_object_present <= next_tick.object_present;
            i_class_valid <= next_tick.class_valid;
            i_class_code <= next_tick.class_code;
            if ($urandom_range(0, 99) < idle_pct)
                tx_gap <= $urandom_range(1, 10);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver back-pressure: random stall bursts, and one long hold-off so
    // that the pipeline fills and the block stalls the sender.
    int   rx_gap = 0;
    int   long_hold_left = 0;
    logic long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
            i_stall <= 1'b1;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            long_hold_left <= LONG_HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            rx_gap <= $urandom_range(0, 9);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result side: every taken result is checked against the oldest prediction.
    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            got.belt_run = o_belt_run;
            got.belt_reverse = o_belt_reverse;
            got.gates_set = o_gates_set;
            got.gate_one = o_gate_one;
            got.gate_two = o_gate_two;
            got.ready_led = o_ready_led;
            got.busy_led = o_busy_led;
            got.capture_request = o_capture_request;
            got.phase = o_phase;
            if (expected_outputs.size() == 0) begin
                note_failure($sformatf("result %0d with no tick pending: %s",
                                       results_seen, show(got)));
            end else begin
                want = expected_outputs.pop_front();
                if (got.belt_run !== want.belt_run || got.belt_reverse !== want.belt_reverse
                    || got.gates_set !== want.gates_set || got.gate_one !== want.gate_one
                    || got.gate_two !== want.gate_two || got.ready_led !== want.ready_led
                    || got.busy_led !== want.busy_led
                    || got.capture_request !== want.capture_request
                    || got.phase !== want.phase)
                    note_failure($sformatf("result %0d mismatch: expected %s, got %s",
                                           results_seen, show(want), show(got)));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[conveyor_sort_sequencer_core] ERROR");
            $finish;
        end
    end

    initial begin
        cfg.rearm_ms = RST_REARM;
        cfg.class_wait_ms = RST_TIMEOUT;
        cfg.sort_first_ms = RST_SORT_FIRST;
        cfg.sort_second_ms = RST_SORT_SECOND;
        cfg.sort_end_ms = RST_SORT_END;
        cfg.jog_ms = RST_JOG_BACK;
        cfg.max_retries = RST_MAX_RETRIES;
        st_phase = PHASE_MOVING;
        st_elapsed = '0;
        st_armed = 1'b1;
        st_retries = '0;
        st_pend_valid = 1'b0;
        st_pend_class = CLS_METAL;
        st_sort_limit = RST_SORT_END;
        st_run = 1'b1;
        st_reverse = 1'b0;
        st_gates_set = 1'b0;
        st_gate_one = 1'b0;
        st_gate_two = 1'b0;
        st_ready = 1'b0;
        st_busy = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings: everything falls inside the rearm window.
        queue_tick(1'b1, 1'b0, CLS_METAL);
        queue_tick(1'b0, 1'b1, CLS_UNKNOWN);
        queue_tick(1'b1, 1'b1, CLS_METAL);
        queue_tick(1'b0, 1'b0, CLS_METAL);
        wait_results();

        // Tiny timings, one retry allowed: walk through the paths below by hand.
        apply_settings(16'd1, 16'd2, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1);
        idle_pct = 15;
        queue_tick(1'b1, 1'b1, CLS_PLASTIC);    // capture drops a same-tick class
        queue_tick(1'b1, 1'b1, CLS_METAL);      // metal sorts with the end time
        repeat (4) queue_tick(1'b0, 1'b0, CLS_METAL);
        queue_tick(1'b0, 1'b0, CLS_METAL);      // rearm window after sorting
        queue_tick(1'b0, 1'b0, CLS_METAL);      // clear beam rearms
        queue_tick(1'b1, 1'b0, CLS_METAL);
        queue_tick(1'b0, 1'b1, CLS_PAPER);
        repeat (3) queue_tick(1'b0, 1'b1, CLS_UNKNOWN);  // class during sort is latched
        queue_tick(1'b0, 1'b0, CLS_METAL);
        queue_tick(1'b1, 1'b0, CLS_METAL);      // object while not armed is ignored
        queue_tick(1'b0, 1'b0, CLS_METAL);
        queue_tick(1'b1, 1'b1, CLS_UNKNOWN);
        queue_tick(1'b1, 1'b1, CLS_UNKNOWN);    // unknown with a retry left jogs back
        repeat (3) queue_tick(1'b0, 1'b0, CLS_METAL);
        queue_tick(1'b0, 1'b0, CLS_METAL);      // jog exit skips the rearm window
        queue_tick(1'b1, 1'b0, CLS_METAL);
        repeat (4) queue_tick(1'b0, 1'b0, CLS_METAL);    // no class: timeout sorts
        wait_results();

        // All timings zero and retries disabled.
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        idle_pct = 10;
        queue_random(370);
        wait_results();

        // Small random timings with the most retries; the long hold-off
        // falls in this stretch.
        apply_settings(16'($urandom_range(0, 6)), 16'($urandom_range(0, 10)),
                       16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(0, 10)), 16'($urandom_range(0, 5)), 16'd3);
        idle_pct = 25;
        queue_random(370);
        wait_results();

        apply_settings(16'($urandom_range(0, 6)), 16'($urandom_range(0, 10)),
                       16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(0, 10)), 16'($urandom_range(0, 5)), 16'd2);
        idle_pct = 40;
        queue_random(370);
        wait_results();

        // Bring the sequencer back to moving before the widest settings, or a
        // latched sort time would keep it busy for a minute.
        idle_pct = 0;
        while (st_phase != PHASE_MOVING) begin
            queue_tick(1'b0, 1'b0, CLS_METAL);
            wait_results();
        end

        // Widest timings apart from a short rearm window, so that a capture happens
        // and the wait and the jog run against full-scale limits. The retry
        // register gets all data bits set.
        apply_settings(16'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (20) queue_tick(1'b0, 1'b0, CLS_METAL);
        queue_tick(1'b1, 1'b1, CLS_PAPER);
        repeat (6) queue_tick(1'b1, 1'b0, CLS_METAL);
        queue_tick(1'b1, 1'b1, CLS_UNKNOWN);
        repeat (5) queue_tick(1'b0, 1'b0, CLS_METAL);
        wait_results();

        // Shrinking the jog time lets the pending jog end.
        apply_settings(16'($urandom_range(0, 6)), 16'($urandom_range(0, 10)),
                       16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(0, 10)), 16'($urandom_range(0, 5)),
                       16'($urandom_range(0, 3)));
        queue_random(370);
        wait_results();

        if (fail_count == 0)
            $display("[conveyor_sort_sequencer_core] OK");
        else
            $display("[conveyor_sort_sequencer_core] ERROR");
        $finish;
    end

endmodule
